/* rtl/core/cat_pkg.sv */
// ----------------------------------------------------------------------------
// cat_pkg: client access table shared types and constants
// Request and result payload structs, command codes and the table entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package cat_pkg;

	// Command codes
	localparam logic [2:0] CMD_CLEAR     = 3'd0;
	localparam logic [2:0] CMD_ADMIT     = 3'd1;
	localparam logic [2:0] CMD_REVOKE_IP = 3'd2;
	localparam logic [2:0] CMD_REVOKE_HW = 3'd3;
	localparam logic [2:0] CMD_QUERY     = 3'd4;

	localparam int IP_W = 32;
	localparam int HW_W = 48;

	// One request
	typedef struct packed {
		logic [2:0]      command;
		logic [IP_W-1:0] ip_addr;
		logic [HW_W-1:0] hw_addr;
		logic            hw_addr_given;
	} req_t;

	// One result
	typedef struct packed {
		logic admitted;
		logic table_full;
	} rsp_t;

	// Stored entry payload; the valid mark lives in flip-flops
	typedef struct packed {
		logic [IP_W-1:0] ip;
		logic [HW_W-1:0] hw;
		logic            hw_known;
	} entry_t;

endpackage

`default_nettype wire

/* rtl/core/client_access_table.sv */
// ----------------------------------------------------------------------------
// client_access_table: table of admitted network clients
// Entries hold an IPv4 address and an optional hardware address; requests
// clear, admit, revoke or query them by scanning the table one entry a cycle.
// ----------------------------------------------------------------------------
//  channel   | ports                  | handshake
//  ----------+------------------------+---------------------------------------
//  request   | start, busy, request   | taken at an edge with start=1, busy=0
//  result    | done, result           | one cycle strobe, cannot be held off
//
//  Each request is scanned through the single read port of the entry memory:
//  one entry is read and compared per cycle, then the finish state applies the
//  admit write. busy drops in the cycle the result is shown, so the next
//  request may be taken there.
//  Reset clears all valid marks at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module client_access_table #(
	parameter int ENTRIES = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire cat_pkg::req_t request,
	output logic               done,
	output cat_pkg::rsp_t      result
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t              state_q;
	cat_pkg::req_t       req_q;
	logic [CNT_W-1:0]    scan_q;
	logic [ENTRIES-1:0]  valid_q;

	cat_pkg::entry_t     mem [ENTRIES];
	cat_pkg::entry_t     rd_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic                live_s1;

	logic                hw_found_q, ip_found_q, free_found_q, hit_q;
	logic [IDX_W-1:0]    hw_idx_q, ip_idx_q, free_idx_q;

	logic                accept;
	logic                ip_nz;
	logic                ent_valid;
	logic                ip_hit, hw_hit;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_idx;
	cat_pkg::entry_t     wr_data;
	logic                set_valid;
	logic                full;

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign ip_nz     = (req_q.ip_addr != '0);
	assign ent_valid = valid_q[idx_s1];
	assign ip_hit    = ent_valid && (rd_s1.ip == req_q.ip_addr);
	assign hw_hit    = ent_valid && rd_s1.hw_known && (rd_s1.hw == req_q.hw_addr);

	// Sequence the request: scan every entry, then finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			scan_q  <= '0;
			live_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					live_s1 <= 1'b0;
					if (start) begin
						scan_q  <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					live_s1 <= (scan_q < CNT_W'(ENTRIES));
					if (scan_q < CNT_W'(ENTRIES)) begin
						scan_q <= scan_q + CNT_W'(1);
					end
					if (live_s1 && (idx_s1 == LAST_IDX)) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					live_s1 <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the request for the whole scan
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= request;
		end
	end

	// Read one entry per cycle; write the admitted entry at finish
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		rd_s1  <= mem[scan_q[IDX_W-1:0]];
		idx_s1 <= scan_q[IDX_W-1:0];
	end

	// Track first hits and first free entry during the scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_found_q   <= 1'b0;
			ip_found_q   <= 1'b0;
			free_found_q <= 1'b0;
			hit_q        <= 1'b0;
			hw_idx_q     <= '0;
			ip_idx_q     <= '0;
			free_idx_q   <= '0;
		end else if (accept) begin
			hw_found_q   <= 1'b0;
			ip_found_q   <= 1'b0;
			free_found_q <= 1'b0;
			hit_q        <= 1'b0;
		end else if ((state_q == ST_SCAN) && live_s1) begin
			if (hw_hit && !hw_found_q) begin
				hw_found_q <= 1'b1;
				hw_idx_q   <= idx_s1;
			end
			if (ip_hit && !ip_found_q) begin
				ip_found_q <= 1'b1;
				ip_idx_q   <= idx_s1;
			end
			if (!ent_valid && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= idx_s1;
			end
			if (ip_hit) begin
				hit_q <= 1'b1;
			end
		end
	end

	// Resolve the admit in priority order
	always_comb begin
		wr_en     = 1'b0;
		wr_idx    = free_idx_q;
		wr_data   = '{ip: req_q.ip_addr, hw: req_q.hw_addr, hw_known: 1'b1};
		set_valid = 1'b0;
		full      = 1'b0;
		if ((state_q == ST_FINISH) && (req_q.command == cat_pkg::CMD_ADMIT) && ip_nz) begin
			priority if (req_q.hw_addr_given && hw_found_q) begin
				wr_en  = 1'b1;
				wr_idx = hw_idx_q;
			end else if (ip_found_q) begin
				wr_en  = req_q.hw_addr_given;
				wr_idx = ip_idx_q;
			end else if (free_found_q) begin
				wr_en     = 1'b1;
				set_valid = 1'b1;
				wr_data   = '{ip: req_q.ip_addr,
					hw: req_q.hw_addr_given ? req_q.hw_addr : '0,
					hw_known: req_q.hw_addr_given};
			end else begin
				full = 1'b1;
			end
		end
	end

	// Update valid marks: revoke during scan, clear and fill at finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if ((state_q == ST_SCAN) && live_s1) begin
			if ((req_q.command == cat_pkg::CMD_REVOKE_IP) && ip_nz && ip_hit) begin
				valid_q[idx_s1] <= 1'b0;
			end
			if ((req_q.command == cat_pkg::CMD_REVOKE_HW) && req_q.hw_addr_given && hw_hit) begin
				valid_q[idx_s1] <= 1'b0;
			end
		end else if (state_q == ST_FINISH) begin
			if (req_q.command == cat_pkg::CMD_CLEAR) begin
				valid_q <= '0;
			end else if (set_valid) begin
				valid_q[wr_idx] <= 1'b1;
			end
		end
	end

	// Drive the result strobe for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done   <= 1'b0;
			result <= '0;
		end else begin
			done <= (state_q == ST_FINISH);
			if (state_q == ST_FINISH) begin
				result.admitted   <= (req_q.command == cat_pkg::CMD_QUERY) && ip_nz && hit_q;
				result.table_full <= full;
			end
		end
	end

endmodule

`default_nettype wire

/* bench/client_access_table_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// client_access_table_test: self-checking bench for the client access table
// Drives clear, admit, revoke and query requests through the start/busy port,
// predicts each verdict from a mirror of the table and checks every done strobe.
// ----------------------------------------------------------------------------

module client_access_table_test;

	import cat_pkg::*;

	localparam int TABLE_DEPTH = 32;
	localparam int IP_POOL = 48;
	localparam int HW_POOL = 40;
	localparam int CHUNKS = 37;
	localparam int CHUNK_LEN = 50;

	// Command codes the block leaves unused
	localparam logic [2:0] CMD_SPARE_A = 3'd5;
	localparam logic [2:0] CMD_SPARE_B = 3'd6;
	localparam logic [2:0] CMD_SPARE_C = 3'd7;

	typedef struct {
		req_t req;
		bit   wait_empty;
	} client_op_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t request = '0;
	logic busy;
	logic done;
	rsp_t result;

	client_op_t client_requests[$];
	rsp_t       expected_verdicts[$];

	// Mirror of the table contents
	bit              mirror_valid[TABLE_DEPTH];
	logic [IP_W-1:0] mirror_ip[TABLE_DEPTH];
	logic [HW_W-1:0] mirror_hw[TABLE_DEPTH];
	bit              mirror_hw_known[TABLE_DEPTH];

	logic [IP_W-1:0] ip_choices[IP_POOL];
	logic [HW_W-1:0] hw_choices[HW_POOL];

	bit req_taken = 1'b0;
	int requests_taken = 0;
	int requests_sent = 0;
	int mismatches = 0;
	int drops_seen = 0;
	int hits_seen = 0;
	int pauses_done = 0;

	client_access_table #(
		.ENTRIES(TABLE_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void wipe_slot(int k);
		mirror_valid[k] = 1'b0;
		mirror_ip[k] = '0;
		mirror_hw[k] = '0;
		mirror_hw_known[k] = 1'b0;
	endfunction

	// Apply one request to the mirror and return the verdict it yields
	function automatic rsp_t predict_access(req_t r);
		rsp_t v;
		int   slot;
		v = '0;
		slot = -1;
		case (r.command)
			CMD_CLEAR: begin
				for (int k = 0; k < TABLE_DEPTH; k++)
					wipe_slot(k);
			end
			CMD_ADMIT: begin
				if (r.ip_addr != '0) begin
					// hardware address match retargets the entry
					if (r.hw_addr_given) begin
						for (int k = 0; k < TABLE_DEPTH; k++)
							if (mirror_valid[k] && mirror_hw_known[k] &&
									mirror_hw[k] == r.hw_addr) begin
								slot = k;
								break;
							end
					end
					if (slot >= 0) begin
						mirror_ip[slot] = r.ip_addr;
					end else begin
						for (int k = 0; k < TABLE_DEPTH; k++)
							if (mirror_valid[k] && mirror_ip[k] == r.ip_addr) begin
								slot = k;
								break;
							end
						if (slot >= 0) begin
							if (r.hw_addr_given) begin
								mirror_hw[slot] = r.hw_addr;
								mirror_hw_known[slot] = 1'b1;
							end
						end else begin
							for (int k = 0; k < TABLE_DEPTH; k++)
								if (!mirror_valid[k]) begin
									slot = k;
									break;
								end
							if (slot >= 0) begin
								mirror_valid[slot] = 1'b1;
								mirror_ip[slot] = r.ip_addr;
								mirror_hw[slot] = r.hw_addr_given ? r.hw_addr : '0;
								mirror_hw_known[slot] = r.hw_addr_given;
							end else begin
								v.table_full = 1'b1;
							end
						end
					end
				end
			end
			CMD_REVOKE_IP: begin
				if (r.ip_addr != '0)
					for (int k = 0; k < TABLE_DEPTH; k++)
						if (mirror_valid[k] && mirror_ip[k] == r.ip_addr)
							wipe_slot(k);
			end
			CMD_REVOKE_HW: begin
				if (r.hw_addr_given)
					for (int k = 0; k < TABLE_DEPTH; k++)
						if (mirror_valid[k] && mirror_hw_known[k] &&
								mirror_hw[k] == r.hw_addr)
							wipe_slot(k);
			end
			CMD_QUERY: begin
				if (r.ip_addr != '0)
					for (int k = 0; k < TABLE_DEPTH; k++)
						if (mirror_valid[k] && mirror_ip[k] == r.ip_addr)
							v.admitted = 1'b1;
			end
			default: ;
		endcase
		return v;
	endfunction

	task automatic queue_request(logic [2:0] cmd, logic [IP_W-1:0] ip,
			logic [HW_W-1:0] hw, logic given);
		client_op_t op;
		op.req.command = cmd;
		op.req.ip_addr = ip;
		op.req.hw_addr = hw;
		op.req.hw_addr_given = given;
		op.wait_empty = 1'b0;
		client_requests.push_back(op);
	endtask

	task automatic queue_pause();
		client_op_t op;
		op.req = '0;
		op.wait_empty = 1'b1;
		client_requests.push_back(op);
	endtask

	function automatic logic [IP_W-1:0] draw_ip();
		int roll;
		roll = $urandom_range(99);
		if (roll < 5)
			return '0;
		else if (roll < 20)
			return $urandom;
		return ip_choices[$urandom_range(IP_POOL - 1)];
	endfunction

	function automatic logic [HW_W-1:0] draw_hw();
		if ($urandom_range(99) < 25)
			return {16'($urandom), 32'($urandom)};
		return hw_choices[$urandom_range(HW_POOL - 1)];
	endfunction

	// Pick a command; admit-heavy chunks drive the table to full
	function automatic logic [2:0] draw_command(int mode);
		int roll;
		roll = $urandom_range(99);
		if (roll < 2)
			return CMD_SPARE_A + 3'($urandom_range(2));
		if (roll < 3)
			return CMD_CLEAR;
		case (mode)
			0: begin
				if (roll < 80) return CMD_ADMIT;
				if (roll < 94) return CMD_QUERY;
				return ($urandom_range(1)) ? CMD_REVOKE_IP : CMD_REVOKE_HW;
			end
			1: begin
				if (roll < 45) return CMD_ADMIT;
				if (roll < 70) return CMD_QUERY;
				if (roll < 85) return CMD_REVOKE_IP;
				return CMD_REVOKE_HW;
			end
			default: begin
				if (roll < 30) return CMD_ADMIT;
				if (roll < 50) return CMD_QUERY;
				if (roll < 75) return CMD_REVOKE_IP;
				return CMD_REVOKE_HW;
			end
		endcase
	endfunction

	// Drive requests at the falling edge; hold start until the request is taken
	always @(negedge clk) begin : drive_requests
		bit go;
		bit idle_now;
		go = 1'b0;
		if (arst_n) begin
			if (req_taken) begin
				void'(client_requests.pop_front());
				req_taken = 1'b0;
				requests_sent++;
			end else if (start) begin
				go = 1'b1;
			end
			if (!go) begin
				// release a pause once every outstanding verdict has come
				if (client_requests.size() > 0 && client_requests[0].wait_empty &&
						expected_verdicts.size() == 0) begin
					void'(client_requests.pop_front());
					pauses_done++;
				end
				idle_now = ($urandom_range(99) < 6) &&
					!(requests_sent >= 700 && requests_sent < 1000);
				if (client_requests.size() > 0 && !client_requests[0].wait_empty &&
						!idle_now) begin
					go = 1'b1;
					request <= client_requests[0].req;
				end
			end
		end
		start <= go;
	end

	// Sample at the rising edge: check verdicts, then predict new requests
	always @(posedge clk) begin : watch_results
		rsp_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_verdicts.size() == 0) begin
					mismatches++;
					if (mismatches < 40)
						$display("%0t: unexpected result admitted=%0b table_full=%0b",
							$time, result.admitted, result.table_full);
				end else begin
					want = expected_verdicts.pop_front();
					if (result.admitted !== want.admitted) begin
						mismatches++;
						if (mismatches < 40)
							$display("%0t: admitted expected %0b actual %0b",
								$time, want.admitted, result.admitted);
					end
					if (result.table_full !== want.table_full) begin
						mismatches++;
						if (mismatches < 40)
							$display("%0t: table_full expected %0b actual %0b",
								$time, want.table_full, result.table_full);
					end
				end
			end
			if (start && !busy) begin
				want = predict_access(request);
				expected_verdicts.push_back(want);
				drops_seen += want.table_full;
				hits_seen += want.admitted;
				requests_taken++;
				req_taken = 1'b1;
			end
		end
	end

	initial begin : run_test
		logic [IP_W-1:0] all_ip;
		logic [HW_W-1:0] all_hw;
		int mode;
		all_ip = '1;
		all_hw = '1;
		for (int k = 0; k < TABLE_DEPTH; k++)
			wipe_slot(k);
		for (int k = 0; k < IP_POOL; k++) begin
			ip_choices[k] = $urandom;
			if (ip_choices[k] == '0)
				ip_choices[k] = 1;
		end
		for (int k = 0; k < HW_POOL; k++)
			hw_choices[k] = {16'($urandom), 32'($urandom)};

		// Directed: zero address, extremes, every match path, spare codes, clear
		queue_request(CMD_QUERY, '0, all_hw, 1'b1);
		queue_request(CMD_ADMIT, '0, all_hw, 1'b1);
		queue_request(CMD_ADMIT, all_ip, all_hw, 1'b1);
		queue_request(CMD_QUERY, all_ip, '0, 1'b0);
		queue_request(CMD_ADMIT, 32'd1, '0, 1'b1);
		queue_request(CMD_ADMIT, 32'd2, all_hw, 1'b1);
		queue_request(CMD_QUERY, all_ip, '0, 1'b0);
		queue_request(CMD_QUERY, 32'd2, '0, 1'b0);
		queue_request(CMD_ADMIT, 32'd1, 48'h0000_5A5A_A5A5, 1'b1);
		queue_request(CMD_ADMIT, 32'd3, all_hw, 1'b0);
		queue_request(CMD_REVOKE_HW, all_ip, all_hw, 1'b0);
		queue_request(CMD_QUERY, 32'd2, '0, 1'b0);
		queue_request(CMD_ADMIT, 32'd3, 48'h00AB_CDEF_0123, 1'b1);
		queue_request(CMD_REVOKE_HW, '0, 48'h0000_5A5A_A5A5, 1'b1);
		queue_request(CMD_QUERY, 32'd1, '0, 1'b0);
		queue_request(CMD_REVOKE_IP, '0, all_hw, 1'b1);
		queue_request(CMD_REVOKE_IP, 32'd3, '0, 1'b0);
		queue_request(CMD_QUERY, 32'd3, '0, 1'b0);
		queue_request(CMD_SPARE_A, all_ip, all_hw, 1'b1);
		queue_request(CMD_SPARE_B, all_ip, all_hw, 1'b1);
		queue_request(CMD_SPARE_C, all_ip, all_hw, 1'b1);
		queue_request(CMD_CLEAR, all_ip, all_hw, 1'b1);
		queue_request(CMD_QUERY, 32'd2, '0, 1'b0);
		queue_pause();

		// Random: chunks of varying command mix drawn from small address pools
		for (int c = 0; c < CHUNKS; c++) begin
			mode = (c == 0) ? 0 : $urandom_range(2);
			if (c > 0 && $urandom_range(7) == 0)
				queue_request(CMD_CLEAR, draw_ip(), draw_hw(), 1'($urandom));
			if ($urandom_range(5) == 0)
				queue_pause();
			for (int i = 0; i < CHUNK_LEN; i++)
				queue_request(draw_command(mode), draw_ip(), draw_hw(),
					($urandom_range(99) < 70));
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Drain: all requests taken, all verdicts in, then a quiet tail
		while (client_requests.size() > 0 || start || expected_verdicts.size() > 0)
			@(posedge clk);
		repeat (TABLE_DEPTH + 8) @(posedge clk);

		$display("Ran %0d requests over %0d quiet points.",
			requests_taken, pauses_done);
		$display("%0d queries hit, %0d admits dropped on a full table.",
			hits_seen, drops_seen);
		if (mismatches == 0)
			$display("client_access_table_test passed");
		else
			$display("client_access_table_test failed");
		$finish;
	end

	// Guard against a hung handshake
	initial begin : watchdog
		#800000;
		$display("client_access_table_test failed");
		$finish;
	end

endmodule

/* files.f */
rtl/core/cat_pkg.sv
rtl/core/client_access_table.sv
bench/client_access_table_test.sv
